[hw/rtl/plcu_pkg.sv]
// ----------------------------------------------------------------------------
// plcu_pkg
// Types and constants shared by the postings-list cache update block.
// ----------------------------------------------------------------------------
package plcu_pkg;

	localparam int CHAN_BITS  = 6;
	localparam int WORD_IN_W  = 10;
	localparam int FREQ_W     = 10;
	localparam int DOC_W      = 32;
	localparam int LID_W      = 16;
	localparam int TIME_W     = 16;
	localparam int ERR_W      = 8;
	localparam int TF_W       = 16;
	localparam int TERM_OUT_W = 16;
	localparam int CNT_W      = 32;
	localparam int BYTES_W    = 40;
	localparam int MIB_SHIFT  = 20;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int BASE_W     = 10;
	localparam int STEP_W     = 6;
	localparam int LIMIT_W    = 13;
	localparam int NLB_W      = 8;
	localparam int CHARGE_W   = 9;

	localparam logic [CHAN_BITS-1:0] CHAN_MAX       = 6'd63;
	localparam logic [CHARGE_W-1:0]  NEW_LIST_EXTRA = 9'd24;
	localparam logic [CHARGE_W-1:0]  NEW_POST_BYTES = 9'd20;
	localparam logic [CHARGE_W-1:0]  ELEM_BYTES     = 9'd12;

	localparam logic [BASE_W-1:0]  BASE_RST  = 10'd0;
	localparam logic [STEP_W-1:0]  STEP_RST  = 6'd1;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 13'd64;
	localparam logic [NLB_W-1:0]   NLB_RST   = 8'd80;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNEL_BASE   = 2'd0,
		CFG_CHANNEL_STEP   = 2'd1,
		CFG_MEMORY_LIMIT   = 2'd2,
		CFG_NEW_LIST_BYTES = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		KIND_NEW_LIST = 3'd0,
		KIND_APPEND   = 3'd1,
		KIND_NEW_POST = 3'd2,
		KIND_DUP      = 3'd3,
		KIND_STALE    = 3'd4,
		KIND_RESET    = 3'd5
	} kind_t;

	typedef struct packed {
		logic              op;
		logic [WORD_IN_W-1:0] word;
		logic [FREQ_W-1:0] freq_bin;
		logic [DOC_W-1:0]  doc_id;
		logic [LID_W-1:0]  lid;
		logic [TIME_W-1:0] time_frame;
		logic [ERR_W-1:0]  quant_err;
	} item_t;

	typedef struct packed {
		kind_t                 kind;
		logic [TERM_OUT_W-1:0] term_out;
		logic [TF_W-1:0]       tf_out;
		logic                  can_flush;
		logic [CNT_W-1:0]      postings_count;
		logic [CNT_W-1:0]      duplicates_count;
	} result_t;

	typedef struct packed {
		logic              present;
		logic [DOC_W-1:0]  doc;
		logic [TF_W-1:0]   tf;
		logic [LID_W-1:0]  lid;
		logic [TIME_W-1:0] tim;
		logic [ERR_W-1:0]  err;
	} entry_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic div_hi;
		logic mem_rd;
		logic exec;
		logic clr_wr;
		logic cnt_clear;
		logic emit_reset;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
	} dp_stat_t;

endpackage

[hw/rtl/plcu_dp.sv]
// ----------------------------------------------------------------------------
// plcu_dp
// Datapath: configuration registers, channel divider, term table, totals.
// ----------------------------------------------------------------------------
module plcu_dp #(
	parameter int CODE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  plcu_pkg::item_t                     item,
	input  logic                                cfg_wr_en,
	input  logic [plcu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [plcu_pkg::CFG_W-1:0]          cfg_data,
	input  plcu_pkg::ctl_cmd_t                  cmd,
	output plcu_pkg::dp_stat_t                  stat,
	output plcu_pkg::result_t                   result
);
	import plcu_pkg::*;

	localparam int TERM_BITS  = CODE_BITS + CHAN_BITS;
	localparam int TERM_COUNT = 1 << TERM_BITS;

	logic [BASE_W-1:0]  base_q;
	logic [STEP_W-1:0]  step_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [NLB_W-1:0]   nlb_q;
	logic [STEP_W-1:0]  step_eff;

	item_t               item_q;
	logic [10:0]         rem_q;
	logic [CHAN_BITS-1:0] quo_q;
	logic                sat_q;
	logic [10:0]         freq_p1;
	logic [10:0]         base_ext;
	logic [10:0]         d_in;
	logic                sat_in;
	logic [10:0]         rem_n;
	logic [CHAN_BITS-1:0] quo_n;
	logic [CHAN_BITS-1:0] chan;
	logic [TERM_BITS-1:0] term;

	entry_t              mem_q [TERM_COUNT];
	entry_t              rd_q;
	entry_t              new_entry;
	entry_t              mem_wd;
	logic                mem_we;
	logic [TERM_BITS-1:0] mem_wa;
	logic [TERM_BITS-1:0] clr_addr_q;

	kind_t               kind_n;
	logic [TF_W-1:0]     tf_n;
	logic                wr_n;
	logic                post_inc;
	logic                dup_inc;
	logic [CHARGE_W-1:0] amt;
	logic [BYTES_W:0]    sum;

	logic [BYTES_W-1:0]  bytes_q;
	logic [CNT_W-1:0]    post_q;
	logic [CNT_W-1:0]    dup_q;
	kind_t               kind_q;
	logic [TERM_OUT_W-1:0] term_q;
	logic [TF_W-1:0]     tf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_RST;
			step_q  <= STEP_RST;
			limit_q <= LIMIT_RST;
			nlb_q   <= NLB_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CHANNEL_BASE:   base_q  <= cfg_data[BASE_W-1:0];
				CFG_CHANNEL_STEP:   step_q  <= cfg_data[STEP_W-1:0];
				CFG_MEMORY_LIMIT:   limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_NEW_LIST_BYTES: nlb_q   <= cfg_data[NLB_W-1:0];
				default: ;
			endcase
		end
	end

	assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;

	// channel: d = freq - base + 1, zero when not positive
	assign freq_p1  = {1'b0, item.freq_bin} + 11'd1;
	assign base_ext = {1'b0, base_q};
	assign d_in     = (freq_p1 > base_ext) ? (freq_p1 - base_ext) : '0;
	assign sat_in   = ({1'b0, d_in} >= {step_eff, 6'b0});

	always_comb begin
		logic [2:0]  sh;
		logic [11:0] dv;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int j = 0; j < 3; j++) begin
			sh = (cmd.div_hi ? 3'd5 : 3'd2) - 3'(j);
			dv = {6'b0, step_eff} << sh;
			if ({1'b0, rem_n} >= dv) begin
				rem_n     = 11'({1'b0, rem_n} - dv);
				quo_n[sh] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			rem_q  <= d_in;
			quo_q  <= '0;
			sat_q  <= sat_in;
		end else if (cmd.div_step) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign chan = sat_q ? CHAN_MAX : quo_q;
	assign term = {CODE_BITS'(item_q.word), chan};

	always_comb begin
		kind_n   = KIND_STALE;
		tf_n     = rd_q.tf;
		wr_n     = 1'b0;
		post_inc = 1'b0;
		dup_inc  = 1'b0;
		amt      = '0;
		new_entry.present = 1'b1;
		new_entry.doc     = item_q.doc_id;
		new_entry.tf      = TF_W'(1);
		new_entry.lid     = item_q.lid;
		new_entry.tim     = item_q.time_frame;
		new_entry.err     = item_q.quant_err;
		if (!rd_q.present) begin
			kind_n   = KIND_NEW_LIST;
			tf_n     = TF_W'(1);
			wr_n     = 1'b1;
			post_inc = 1'b1;
			amt      = {1'b0, nlb_q} + NEW_LIST_EXTRA;
		end else if (item_q.doc_id < rd_q.doc) begin
			kind_n = KIND_STALE;
		end else if (item_q.doc_id == rd_q.doc) begin
			if (item_q.lid == rd_q.lid && item_q.time_frame == rd_q.tim &&
				item_q.quant_err == rd_q.err) begin
				kind_n  = KIND_DUP;
				dup_inc = 1'b1;
			end else begin
				kind_n = KIND_APPEND;
				tf_n   = (rd_q.tf == '1) ? rd_q.tf : rd_q.tf + TF_W'(1);
				new_entry.tf = tf_n;
				wr_n   = 1'b1;
				amt    = ELEM_BYTES;
			end
		end else begin
			kind_n   = KIND_NEW_POST;
			tf_n     = TF_W'(1);
			wr_n     = 1'b1;
			post_inc = 1'b1;
			amt      = NEW_POST_BYTES;
		end
	end

	assign mem_we = cmd.clr_wr | (cmd.exec & wr_n);
	assign mem_wa = cmd.clr_wr ? clr_addr_q : term;
	assign mem_wd = cmd.clr_wr ? entry_t'('0) : new_entry;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem_q[term];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign stat.clr_last = &clr_addr_q;

	assign sum = {1'b0, bytes_q} + (BYTES_W+1)'(amt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			post_q  <= '0;
			dup_q   <= '0;
		end else if (cmd.cnt_clear) begin
			bytes_q <= '0;
			post_q  <= '0;
			dup_q   <= '0;
		end else if (cmd.exec) begin
			bytes_q <= sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
			post_q  <= post_q + CNT_W'(post_inc);
			dup_q   <= dup_q + CNT_W'(dup_inc);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			kind_q <= kind_n;
			term_q <= TERM_OUT_W'(term);
			tf_q   <= tf_n;
		end else if (cmd.emit_reset) begin
			kind_q <= KIND_RESET;
			term_q <= '0;
			tf_q   <= '0;
		end
	end

	assign result.kind             = kind_q;
	assign result.term_out         = term_q;
	assign result.tf_out           = tf_q;
	assign result.can_flush        = bytes_q[BYTES_W-1:MIB_SHIFT] >=
		(BYTES_W-MIB_SHIFT)'(limit_q);
	assign result.postings_count   = post_q;
	assign result.duplicates_count = dup_q;

endmodule

[hw/rtl/plcu_ctrl.sv]
// ----------------------------------------------------------------------------
// plcu_ctrl
// Controller: sequences table sweep, channel division, table read and update.
// ----------------------------------------------------------------------------
module plcu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                op,
	input  plcu_pkg::dp_stat_t  stat,
	output plcu_pkg::ctl_cmd_t  cmd,
	output logic                busy,
	output logic                done
);
	import plcu_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CLEAR = 6'b000010,
		ST_DIV_A = 6'b000100,
		ST_DIV_B = 6'b001000,
		ST_READ  = 6'b010000,
		ST_EXEC  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rpt_q;
	logic   rpt_d;
	logic   done_q;
	logic   done_d;

	always_comb begin
		state_d = state_q;
		rpt_d   = rpt_q;
		done_d  = 1'b0;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (op) begin
						cmd.cnt_clear = 1'b1;
						rpt_d         = 1'b1;
						state_d       = ST_CLEAR;
					end else begin
						state_d = ST_DIV_A;
					end
				end
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					cmd.emit_reset = rpt_q;
					done_d         = rpt_q;
					rpt_d          = 1'b0;
					state_d        = ST_IDLE;
				end
			end
			ST_DIV_A: begin
				cmd.div_step = 1'b1;
				cmd.div_hi   = 1'b1;
				state_d      = ST_DIV_B;
			end
			ST_DIV_B: begin
				cmd.div_step = 1'b1;
				state_d      = ST_READ;
			end
			ST_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				done_d   = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			rpt_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rpt_q   <= rpt_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

[hw/rtl/postings_list_cache_update_top.sv]
// ----------------------------------------------------------------------------
// postings_list_cache_update_top
// Per-term last-posting table update with running totals and flush request.
//
//   channel   signals                              transfer
//   -------   ----------------------------------   -------------------------
//   item      start, busy, item                    start & !busy
//   result    done, result                         done (one cycle, no stall)
//   config    cfg_wr_en, cfg_index, cfg_data       cfg_wr_en
//
// An add item holds busy through two 3-bit divider steps for the channel,
// a table read and a table update; its result beat is registered from the
// update. A new item is taken only while busy is low, so the divider and the
// table read-modify-write set the item rate.
// After reset, and for each reset item, a sweep clears all 2^(CODE_BITS+6)
// entries of the term table one entry a cycle, with busy high. A reset item's
// beat comes when the sweep ends. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module postings_list_cache_update_top #(
	parameter int CODE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  plcu_pkg::item_t                 item,
	output logic                            done,
	output plcu_pkg::result_t               result,
	input  logic                            cfg_wr_en,
	input  logic [plcu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [plcu_pkg::CFG_W-1:0]      cfg_data
);
	import plcu_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	plcu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (item.op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	plcu_dp #(
		.CODE_BITS (CODE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

[hw/rtl/plcu_chk.sv]
// ----------------------------------------------------------------------------
// plcu_chk
// Port-level checks on the postings-list cache update block.
// ----------------------------------------------------------------------------
module plcu_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input plcu_pkg::item_t     item,
	input logic                done,
	input plcu_pkg::result_t   result
);
	import plcu_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat repeated");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_add_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item.op) |-> ##5 done)
		else $error("add result beat not on time");

	a_reset_totals: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.kind == KIND_RESET) |->
		(result.postings_count == '0 && result.duplicates_count == '0 &&
		result.term_out == '0 && result.tf_out == '0))
		else $error("reset beat with nonzero totals");

endmodule

bind postings_list_cache_update_top plcu_chk u_chk (.*);

[verif/tb_postings_list_cache_update_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_postings_list_cache_update_top
// Self-checking bench for the postings-list cache update block. A short
// directed table, mostly with literal expectations, runs at the reset
// register values. Several register sets follow: zero step, zero limit and
// field maxima among them. Each set gets random fingerprint beats, mostly
// term-colliding sequences with some noise and stale ids. Every result beat
// is compared field by field with its literal expectation, or else with a
// behavioral model of the term table and the running totals.
// ----------------------------------------------------------------------------
module tb_postings_list_cache_update_top;
	import plcu_pkg::*;

	localparam int   CLK_PERIOD  = 10;
	localparam int   CODE_BITS   = 10;
	localparam int   TERM_N      = 1 << (CODE_BITS + CHAN_BITS);
	localparam int   STALL_LIMIT = 300000;
	localparam int   PHASES      = 6;
	localparam int   PHASE_BEATS = 225;
	localparam logic OP_ADD      = 1'b0;
	localparam logic OP_RESET    = 1'b1;

	typedef struct {
		item_t   it;
		bit      lit;
		result_t want;
	} dir_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	item_t                item      = '0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 busy;
	logic                 done;
	result_t              result;

	entry_t               term_tbl [TERM_N];
	logic [BYTES_W-1:0]   bytes_used;
	logic [CNT_W-1:0]     n_postings;
	logic [CNT_W-1:0]     n_dups;
	logic [BASE_W-1:0]    ch_base;
	logic [STEP_W-1:0]    ch_step;
	logic [LIMIT_W-1:0]   lim_mb;
	logic [NLB_W-1:0]     list_bytes;

	result_t              upcoming_updates [$];
	result_t              due_update;
	result_t              next_update;
	bit                   row_literal = 1'b0;
	result_t              row_want    = '0;
	int                   n_items     = 0;
	int                   n_results   = 0;
	int                   fails       = 0;
	int                   idle_cycles = 0;
	int                   kind_seen [6] = '{default: 0};

	logic [DOC_W-1:0]     cur_doc;
	logic [WORD_IN_W-1:0] pool_word [8];
	logic [FREQ_W-1:0]    pool_freq [8];
	item_t                prev_fp = '0;

	postings_list_cache_update_top #(.CODE_BITS(CODE_BITS)) dut (
		.clk, .arst_n, .start, .busy, .item, .done, .result,
		.cfg_wr_en, .cfg_index, .cfg_data
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void wipe_cache();
		foreach (term_tbl[i]) term_tbl[i] = '0;
		bytes_used = '0;
		n_postings = '0;
		n_dups     = '0;
	endfunction

	function automatic void add_bytes(input int unsigned n);
		logic [BYTES_W:0] sum;
		sum = {1'b0, bytes_used} + (BYTES_W+1)'(n);
		bytes_used = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
	endfunction

	function automatic logic [CHAN_BITS-1:0] freq_channel(input logic [FREQ_W-1:0] f);
		int fi, bi, d, s;
		fi = f;
		bi = ch_base;
		s  = (ch_step == 0) ? 1 : ch_step;
		d  = fi - bi + 1;
		if (d <= 0)
			return '0;
		d = d / s;
		return (d > int'(CHAN_MAX)) ? CHAN_MAX : d[CHAN_BITS-1:0];
	endfunction

	function automatic result_t postings_update(input item_t it);
		result_t               r;
		entry_t                e;
		logic [TERM_OUT_W-1:0] t;
		bit                    take;
		r    = '0;
		take = 1'b0;
		if (it.op == OP_RESET) begin
			wipe_cache();
			r.kind = KIND_RESET;
		end else begin
			t = {it.word[CODE_BITS-1:0], freq_channel(it.freq_bin)};
			e = term_tbl[t];
			if (!e.present) begin
				r.kind = KIND_NEW_LIST;
				add_bytes(32'(list_bytes) + 32'(NEW_LIST_EXTRA));
				take = 1'b1;
			end else if (it.doc_id > e.doc) begin
				r.kind = KIND_NEW_POST;
				add_bytes(32'(NEW_POST_BYTES));
				take = 1'b1;
			end else if (it.doc_id < e.doc) begin
				r.kind = KIND_STALE;
			end else if (it.lid == e.lid && it.time_frame == e.tim && it.quant_err == e.err) begin
				r.kind = KIND_DUP;
				n_dups = n_dups + 1'b1;
			end else begin
				r.kind = KIND_APPEND;
				if (e.tf != '1)
					e.tf = e.tf + 1'b1;
				add_bytes(32'(ELEM_BYTES));
				e.lid = it.lid;
				e.tim = it.time_frame;
				e.err = it.quant_err;
			end
			if (take) begin
				e.present  = 1'b1;
				e.doc      = it.doc_id;
				e.tf       = TF_W'(1);
				e.lid      = it.lid;
				e.tim      = it.time_frame;
				e.err      = it.quant_err;
				n_postings = n_postings + 1'b1;
			end
			term_tbl[t] = e;
			r.term_out  = t;
			r.tf_out    = e.tf;
		end
		r.can_flush        = (bytes_used >> MIB_SHIFT) >= lim_mb;
		r.postings_count   = n_postings;
		r.duplicates_count = n_dups;
		return r;
	endfunction

	function automatic bit same_result(input result_t a, input result_t b);
		return a.kind === b.kind && a.term_out === b.term_out && a.tf_out === b.tf_out &&
			a.can_flush === b.can_flush && a.postings_count === b.postings_count &&
			a.duplicates_count === b.duplicates_count;
	endfunction

	function automatic dir_row_t mk_row(input logic op, input logic [9:0] w, f,
		input logic [31:0] d, input logic [15:0] l, tm, input logic [7:0] e,
		input bit lit, input kind_t k, input logic [15:0] t, tf, input logic fl,
		input logic [31:0] pc, dc);
		dir_row_t row;
		row.it                    = '0;
		row.it.op                 = op;
		row.it.word               = w;
		row.it.freq_bin           = f;
		row.it.doc_id             = d;
		row.it.lid                = l;
		row.it.time_frame         = tm;
		row.it.quant_err          = e;
		row.lit                   = lit;
		row.want                  = '0;
		row.want.kind             = k;
		row.want.term_out         = t;
		row.want.tf_out           = tf;
		row.want.can_flush        = fl;
		row.want.postings_count   = pc;
		row.want.duplicates_count = dc;
		return row;
	endfunction

	task automatic put_fingerprint(input item_t it, input bit lit, input result_t want);
		@(negedge clk);
		start       <= 1'b1;
		item        <= it;
		row_literal = lit;
		row_want    = want;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic hold_off(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic settle();
		@(negedge clk);
		start       <= 1'b0;
		row_literal = 1'b0;
		while (upcoming_updates.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_settings(input logic [BASE_W-1:0] b, input logic [STEP_W-1:0] s,
		input logic [LIMIT_W-1:0] l, input logic [NLB_W-1:0] n);
		cfg_idx_t   idx [4];
		logic [CFG_W-1:0] val [4];
		idx[0] = CFG_CHANNEL_BASE;   val[0] = CFG_W'(b);
		idx[1] = CFG_CHANNEL_STEP;   val[1] = CFG_W'(s);
		idx[2] = CFG_MEMORY_LIMIT;   val[2] = CFG_W'(l);
		idx[3] = CFG_NEW_LIST_BYTES; val[3] = CFG_W'(n);
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
		end
		@(negedge clk);
		cfg_wr_en  <= 1'b0;
		ch_base    = b;
		ch_step    = s;
		lim_mb     = l;
		list_bytes = n;
	endtask

	task automatic gen_fingerprint(output item_t it);
		int sel;
		int k;
		sel           = $urandom_range(0, 99);
		k             = $urandom_range(0, 7);
		it            = '0;
		it.op         = OP_ADD;
		it.word       = pool_word[k];
		it.freq_bin   = pool_freq[k];
		it.lid        = LID_W'($urandom_range(0, 3));
		it.time_frame = TIME_W'($urandom_range(0, 3));
		it.quant_err  = ERR_W'($urandom_range(0, 1));
		if ($urandom_range(0, 599) == 0) begin
			it.op     = OP_RESET;
			it.doc_id = $urandom;
		end else if (sel < 10) begin
			it.word       = WORD_IN_W'($urandom_range(0, 1023));
			it.freq_bin   = FREQ_W'($urandom_range(0, 1023));
			it.doc_id     = $urandom;
			it.lid        = LID_W'($urandom_range(0, 65535));
			it.time_frame = TIME_W'($urandom_range(0, 65535));
			it.quant_err  = ERR_W'($urandom_range(0, 255));
		end else if (sel < 22) begin
			it = prev_fp;
		end else if (sel < 28) begin
			it.doc_id = cur_doc - $urandom_range(1, 1000);
		end else begin
			if ($urandom_range(0, 3) == 0)
				cur_doc = cur_doc + $urandom_range(1, 3);
			it.doc_id = cur_doc;
		end
		if (it.op == OP_ADD)
			prev_fp = it;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				n_results++;
				if (upcoming_updates.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: result beat with nothing outstanding, kind %0d term %h",
							$time, result.kind, result.term_out);
				end else begin
					due_update = upcoming_updates.pop_front();
					if (!same_result(due_update, result)) begin
						fails++;
						if (fails <= 10)
							$display({"%0t: mismatch (expected/actual) kind %0d/%0d term %h/%h ",
								"tf %0d/%0d flush %0b/%0b postings %0d/%0d dups %0d/%0d"},
								$time, due_update.kind, result.kind,
								due_update.term_out, result.term_out,
								due_update.tf_out, result.tf_out,
								due_update.can_flush, result.can_flush,
								due_update.postings_count, result.postings_count,
								due_update.duplicates_count, result.duplicates_count);
					end
				end
			end
			if (start && !busy) begin
				n_items++;
				next_update = postings_update(item);
				if (row_literal)
					next_update = row_want;
				kind_seen[int'(next_update.kind)]++;
				upcoming_updates = {upcoming_updates, next_update};
			end
			idle_cycles = (done || (start && !busy) || cfg_wr_en) ? 0 : idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		dir_row_t           rows [$];
		item_t              fp;
		int                 burst_left;
		logic [BASE_W-1:0]  ph_base [PHASES];
		logic [STEP_W-1:0]  ph_step [PHASES];
		logic [LIMIT_W-1:0] ph_lim  [PHASES];
		logic [NLB_W-1:0]   ph_nlb  [PHASES];

		rows = {rows, mk_row(OP_ADD, 10'h000, 10'h000, 32'd0, 16'h0000, 16'h0000, 8'h00,
			1, KIND_NEW_LIST, 16'h0001, 16'd1, 1'b0, 32'd1, 32'd0)};
		rows = {rows, mk_row(OP_ADD, 10'h000, 10'h000, 32'd0, 16'h0000, 16'h0000, 8'h00,
			1, KIND_DUP, 16'h0001, 16'd1, 1'b0, 32'd1, 32'd1)};
		rows = {rows, mk_row(OP_ADD, 10'h000, 10'h000, 32'd0, 16'h0001, 16'h0000, 8'h00,
			1, KIND_APPEND, 16'h0001, 16'd2, 1'b0, 32'd1, 32'd1)};
		rows = {rows, mk_row(OP_ADD, 10'h000, 10'h000, 32'd0, 16'h0001, 16'h0001, 8'h00,
			1, KIND_APPEND, 16'h0001, 16'd3, 1'b0, 32'd1, 32'd1)};
		rows = {rows, mk_row(OP_ADD, 10'h000, 10'h000, 32'd0, 16'h0001, 16'h0001, 8'h01,
			1, KIND_APPEND, 16'h0001, 16'd4, 1'b0, 32'd1, 32'd1)};
		rows = {rows, mk_row(OP_ADD, 10'h000, 10'h000, 32'd5, 16'h0000, 16'h0000, 8'h00,
			1, KIND_NEW_POST, 16'h0001, 16'd1, 1'b0, 32'd2, 32'd1)};
		rows = {rows, mk_row(OP_ADD, 10'h000, 10'h000, 32'd4, 16'h0000, 16'h0000, 8'h00,
			1, KIND_STALE, 16'h0001, 16'd1, 1'b0, 32'd2, 32'd1)};
		rows = {rows, mk_row(OP_ADD, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			8'hFF, 1, KIND_NEW_LIST, 16'hFFFF, 16'd1, 1'b0, 32'd3, 32'd1)};
		rows = {rows, mk_row(OP_ADD, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			8'hFF, 1, KIND_DUP, 16'hFFFF, 16'd1, 1'b0, 32'd3, 32'd2)};
		rows = {rows, mk_row(OP_ADD, 10'h3FF, 10'h3FF, 32'd0, 16'h0000, 16'h0000, 8'h00,
			1, KIND_STALE, 16'hFFFF, 16'd1, 1'b0, 32'd3, 32'd2)};
		rows = {rows, mk_row(OP_ADD, 10'h2AA, 10'h155, 32'd7, 16'h5555, 16'hAAAA, 8'h55,
			0, KIND_NEW_LIST, '0, '0, 1'b0, '0, '0)};
		rows = {rows, mk_row(OP_ADD, 10'h155, 10'h2AA, 32'd7, 16'hAAAA, 16'h5555, 8'hAA,
			0, KIND_NEW_LIST, '0, '0, 1'b0, '0, '0)};
		rows = {rows, mk_row(OP_ADD, 10'h000, 10'd61, 32'd9, 16'h0000, 16'h0000, 8'h00,
			0, KIND_NEW_LIST, '0, '0, 1'b0, '0, '0)};
		rows = {rows, mk_row(OP_ADD, 10'h000, 10'd62, 32'd9, 16'h0000, 16'h0000, 8'h00,
			0, KIND_NEW_LIST, '0, '0, 1'b0, '0, '0)};
		rows = {rows, mk_row(OP_ADD, 10'h000, 10'h000, 32'd5, 16'h0000, 16'h0000, 8'h00,
			0, KIND_NEW_LIST, '0, '0, 1'b0, '0, '0)};
		rows = {rows, mk_row(OP_RESET, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			8'hFF, 1, KIND_RESET, 16'h0000, 16'd0, 1'b0, 32'd0, 32'd0)};
		rows = {rows, mk_row(OP_ADD, 10'h000, 10'h000, 32'd0, 16'h0000, 16'h0000, 8'h00,
			1, KIND_NEW_LIST, 16'h0001, 16'd1, 1'b0, 32'd1, 32'd0)};

		ph_base[0] = '0;     ph_step[0] = '0;    ph_lim[0] = '0;     ph_nlb[0] = '0;
		ph_base[1] = '1;     ph_step[1] = '1;    ph_lim[1] = '1;     ph_nlb[1] = '1;
		ph_base[2] = 10'd512; ph_step[2] = 6'd8; ph_lim[2] = 13'd1;  ph_nlb[2] = 8'd80;
		for (int p = 3; p < PHASES; p++) begin
			ph_base[p] = BASE_W'($urandom_range(0, 1023));
			ph_step[p] = STEP_W'($urandom_range(0, 63));
			ph_lim[p]  = LIMIT_W'($urandom_range(0, 8191));
			ph_nlb[p]  = NLB_W'($urandom_range(0, 255));
		end

		wipe_cache();
		ch_base    = BASE_RST;
		ch_step    = STEP_RST;
		lim_mb     = LIMIT_RST;
		list_bytes = NLB_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		foreach (rows[i]) begin
			hold_off($urandom_range(0, 3));
			put_fingerprint(rows[i].it, rows[i].lit, rows[i].want);
		end
		settle();

		for (int p = 0; p < PHASES; p++) begin
			load_settings(ph_base[p], ph_step[p], ph_lim[p], ph_nlb[p]);
			for (int k = 0; k < 8; k++) begin
				pool_word[k] = WORD_IN_W'($urandom_range(0, 1023));
				pool_freq[k] = FREQ_W'($urandom_range(0, 1023));
			end
			cur_doc    = $urandom;
			burst_left = 0;
			for (int i = 0; i < PHASE_BEATS; i++) begin
				if (burst_left == 0) begin
					hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
					burst_left = $urandom_range(1, 24);
				end
				burst_left--;
				if ($urandom_range(0, 149) == 0)
					settle();
				gen_fingerprint(fp);
				put_fingerprint(fp, 1'b0, '0);
			end
			settle();
		end

		settle();
		repeat (20) @(posedge clk);
		if (upcoming_updates.size() != 0) begin
			$display("%0d expected result beats never arrived", upcoming_updates.size());
			fails += upcoming_updates.size();
		end
		$display({"Run covered %0d fingerprint beats and %0d result beats: %0d new lists, ",
			"%0d appends, %0d new postings, %0d duplicates, %0d stale, %0d cache resets"},
			n_items, n_results, kind_seen[KIND_NEW_LIST], kind_seen[KIND_APPEND],
			kind_seen[KIND_NEW_POST], kind_seen[KIND_DUP], kind_seen[KIND_STALE],
			kind_seen[KIND_RESET]);
		$display({"Register sets: reset values plus %0d more (zero step, zero limit and field ",
			"maxima among them)"}, PHASES);
		if (fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
